FILE: rtl/xms_pkg.sv
// ----------------------------------------------------------------------------
// xms_pkg
// Shared types and constants for the XORSAT Metropolis spin update block.
// ----------------------------------------------------------------------------
package xms_pkg;

    localparam int SITES_DEFAULT = 1024;
    localparam int DEGREE        = 3;
    localparam int MEMBERS       = 3;

    localparam int SITE_W   = 10;
    localparam int SLOT_IW  = 2;
    localparam int KIND_W   = 2;
    localparam int RAND_W   = 32;
    localparam int THRESH_W = 33;
    localparam int MAG_W    = 12;
    localparam int NUM_THR  = 4;
    localparam int CFG_AW   = 2;

    // coupling sign on top, members c/b/a below
    localparam int SLOT_W = 1 + MEMBERS * SITE_W;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 33'h1_0000_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_SPIN   = 2'd0,
        KIND_SLOT   = 2'd1,
        KIND_UPDATE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OWN,
        ST_GOT,
        ST_SLOT,
        ST_SLOT_GOT,
        ST_MEM,
        ST_MEM_GOT,
        ST_DECIDE,
        ST_FIN
    } t_state;

endpackage

FILE: rtl/xorsat_metropolis_spin_update_top.sv
// ----------------------------------------------------------------------------
// xorsat_metropolis_spin_update_top
// Metropolis single-site update for a 3-spin XORSAT model on a regular graph.
// ----------------------------------------------------------------------------
// After reset the block sets all DEPTH = min(SITES, 1024) spins to +1 and
// takes no word meanwhile; threshold writes are taken at any time. Each input
// word yields exactly one output word. A spin load, slot load or idle kind
// reads the own spin and then yields its result; an update also fetches the
// nine member spins one at a time through the single read port of the spin
// RAM, plus one slot RAM read per interaction.
// The block takes one word at a time, but accepts the next one while the last
// result still waits on the output.
module xorsat_metropolis_spin_update_top #(
    parameter int SITES = xms_pkg::SITES_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [xms_pkg::CFG_AW-1:0]          i_cfg_addr,
    input  logic [xms_pkg::THRESH_W-1:0]        i_cfg_data,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // site[9:0] slot[11:10] coupling_neg[12] member_a[22:13] member_b[32:23]
    // member_c[42:33] spin_load[43] random_word[75:44], zero pad [79:76]
    input  logic [xms_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // kind[1:0]
    input  logic [xms_pkg::KIND_W-1:0]          i_s_axis_tuser,
    // output stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // out_site[9:0] out_spin[10] flipped[11] magnetization[23:12]
    output logic [xms_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int SITE_W = xms_pkg::SITE_W;
    localparam int MAG_W  = xms_pkg::MAG_W;
    localparam int SLOT_W = xms_pkg::SLOT_W;
    localparam int DEPTH  = (SITES < (2 ** SITE_W)) ? SITES : (2 ** SITE_W);
    localparam int AW     = $clog2(DEPTH);
    localparam int SDEPTH = DEPTH * xms_pkg::DEGREE;
    localparam int SAW    = $clog2(SDEPTH);
    localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(SITES);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(DEPTH - 1);

    xms_pkg::t_state r_state, n_state;

    // control registers
    logic                          r_out_valid, n_out_valid;
    logic [MAG_W-1:0]              r_mag, n_mag;
    logic [AW-1:0]                 r_clr, n_clr;
    logic [xms_pkg::THRESH_W-1:0]  r_thresh [xms_pkg::NUM_THR];

    // item and working registers
    logic [xms_pkg::KIND_W-1:0]    r_kind, n_kind;
    logic [SITE_W-1:0]             r_site, n_site;
    logic [xms_pkg::SLOT_IW-1:0]   r_slot_idx, n_slot_idx;
    logic                          r_cneg, n_cneg;
    logic [3*SITE_W-1:0]           r_members, n_members;
    logic                          r_sload, n_sload;
    logic [xms_pkg::RAND_W-1:0]    r_rand, n_rand;
    logic                          r_valid, n_valid;
    logic                          r_own, n_own;
    logic [SLOT_W-1:0]             r_slot, n_slot;
    logic                          r_par, n_par;
    logic signed [3:0]             r_sum, n_sum;
    logic [1:0]                    r_j, n_j;
    logic [1:0]                    r_k, n_k;
    logic                          r_flip, n_flip;
    logic [xms_pkg::OUT_DATA_W-1:0] r_out, n_out;

    // RAM ports
    logic                          spin_we;
    logic [AW-1:0]                 spin_waddr, spin_raddr;
    logic                          spin_wdata, spin_rdata;
    logic                          slot_we;
    logic [SAW-1:0]                slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]             slot_wdata, slot_rdata;

    logic                          in_fire;
    logic                          out_free;
    logic [SITE_W-1:0]             in_site;
    logic [SITE_W-1:0]             mem_site;
    logic                          mem_valid;
    logic                          par_next;
    logic [SITE_W+1:0]             slot_elem;
    logic [SITE_W+1:0]             rd_elem;
    logic signed [3:0]             ind;
    logic                          new_spin;
    logic                          spin_change;

    assign in_site  = i_s_axis_tdata[SITE_W-1:0];
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // slot element index = 3*site + slot
    assign slot_elem = {1'b0, r_site, 1'b0} + {2'b00, r_site}
                     + (SITE_W+2)'(r_slot_idx);
    assign rd_elem   = {1'b0, r_site, 1'b0} + {2'b00, r_site} + (SITE_W+2)'(r_j);

    always_comb begin
        case (r_k)
            2'd0:    mem_site = r_slot[SITE_W-1:0];
            2'd1:    mem_site = r_slot[2*SITE_W-1:SITE_W];
            default: mem_site = r_slot[3*SITE_W-1:2*SITE_W];
        endcase
    end

    assign mem_valid = 32'(mem_site) < SITES;
    assign par_next  = r_par ^ (mem_valid & spin_rdata);
    assign ind       = r_sum - (r_own ? 4'sd0 : 4'sd1);

    always_comb begin
        case (r_kind)
            xms_pkg::KIND_SPIN:   new_spin = r_sload;
            xms_pkg::KIND_UPDATE: new_spin = r_own ^ r_flip;
            default:              new_spin = r_own;
        endcase
    end
    assign spin_change = r_valid && (new_spin != r_own)
                      && (r_kind == xms_pkg::KIND_SPIN || r_kind == xms_pkg::KIND_UPDATE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_mag       = r_mag;
        n_clr       = r_clr;
        n_kind      = r_kind;
        n_site      = r_site;
        n_slot_idx  = r_slot_idx;
        n_cneg      = r_cneg;
        n_members   = r_members;
        n_sload     = r_sload;
        n_rand      = r_rand;
        n_valid     = r_valid;
        n_own       = r_own;
        n_slot      = r_slot;
        n_par       = r_par;
        n_sum       = r_sum;
        n_j         = r_j;
        n_k         = r_k;
        n_flip      = r_flip;
        n_out       = r_out;

        o_s_axis_tready = 1'b0;
        spin_we    = 1'b0;
        spin_waddr = r_site[AW-1:0];
        spin_wdata = new_spin;
        spin_raddr = r_site[AW-1:0];
        slot_we    = 1'b0;
        slot_waddr = slot_elem[SAW-1:0];
        slot_wdata = {r_cneg, r_members};
        slot_raddr = rd_elem[SAW-1:0];

        case (r_state)
            xms_pkg::ST_CLEAR: begin
                spin_we    = 1'b1;
                spin_waddr = r_clr;
                spin_wdata = 1'b0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = xms_pkg::ST_IDLE;
                end
            end
            xms_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_fire) begin
                    n_kind     = i_s_axis_tuser;
                    n_site     = in_site;
                    n_slot_idx = i_s_axis_tdata[11:10];
                    n_cneg     = i_s_axis_tdata[12];
                    n_members  = i_s_axis_tdata[42:13];
                    n_sload    = i_s_axis_tdata[43];
                    n_rand     = i_s_axis_tdata[75:44];
                    n_valid    = 32'(in_site) < SITES;
                    n_flip     = 1'b0;
                    n_state    = (32'(in_site) < SITES) ? xms_pkg::ST_OWN : xms_pkg::ST_FIN;
                end
            end
            xms_pkg::ST_OWN: begin
                n_state = xms_pkg::ST_GOT;
            end
            xms_pkg::ST_GOT: begin
                n_own = spin_rdata;
                if (r_kind == xms_pkg::KIND_UPDATE) begin
                    n_j     = '0;
                    n_sum   = '0;
                    n_state = xms_pkg::ST_SLOT;
                end else begin
                    n_state = xms_pkg::ST_FIN;
                end
            end
            xms_pkg::ST_SLOT: begin
                n_state = xms_pkg::ST_SLOT_GOT;
            end
            xms_pkg::ST_SLOT_GOT: begin
                n_slot  = slot_rdata;
                n_par   = slot_rdata[SLOT_W-1];
                n_k     = '0;
                n_state = xms_pkg::ST_MEM;
            end
            xms_pkg::ST_MEM: begin
                spin_raddr = mem_site[AW-1:0];
                n_state    = xms_pkg::ST_MEM_GOT;
            end
            xms_pkg::ST_MEM_GOT: begin
                spin_raddr = mem_site[AW-1:0];
                n_par      = par_next;
                if (r_k == 2'(xms_pkg::MEMBERS - 1)) begin
                    n_sum = par_next ? (r_sum - 4'sd1) : (r_sum + 4'sd1);
                    n_j   = r_j + 1'b1;
                    n_state = (r_j == 2'(xms_pkg::DEGREE - 1)) ? xms_pkg::ST_DECIDE
                                                                 : xms_pkg::ST_SLOT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = xms_pkg::ST_MEM;
                end
            end
            xms_pkg::ST_DECIDE: begin
                // negative index always flips; indexes 0..3 draw against a threshold
                if (ind < 0) begin
                    n_flip = 1'b1;
                end else begin
                    n_flip = {1'b0, r_rand} < r_thresh[ind[1:0]];
                end
                n_state = xms_pkg::ST_FIN;
            end
            xms_pkg::ST_FIN: begin
                if (out_free) begin
                    spin_we = spin_change;
                    slot_we = r_valid && (r_kind == xms_pkg::KIND_SLOT)
                           && (r_slot_idx < 2'(xms_pkg::DEGREE));
                    if (spin_change) begin
                        n_mag = new_spin ? (r_mag - MAG_W'(2)) : (r_mag + MAG_W'(2));
                    end
                    n_out = {(spin_change ? (new_spin ? (r_mag - MAG_W'(2))
                                                      : (r_mag + MAG_W'(2)))
                                          : r_mag),
                             r_flip,
                             r_valid & new_spin,
                             r_site};
                    n_out_valid = 1'b1;
                    n_state     = xms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = xms_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xms_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
            r_mag       <= MAG_RESET;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_mag       <= n_mag;
            r_clr       <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < xms_pkg::NUM_THR; i++) begin
                r_thresh[i] <= xms_pkg::THRESH_RESET;
            end
        end else if (i_cfg_we) begin
            r_thresh[i_cfg_addr] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_site     <= n_site;
        r_slot_idx <= n_slot_idx;
        r_cneg     <= n_cneg;
        r_members  <= n_members;
        r_sload    <= n_sload;
        r_rand     <= n_rand;
        r_valid    <= n_valid;
        r_own      <= n_own;
        r_slot     <= n_slot;
        r_par      <= n_par;
        r_sum      <= n_sum;
        r_j        <= n_j;
        r_k        <= n_k;
        r_flip     <= n_flip;
        r_out      <= n_out;
    end

    xms_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (spin_we),
        .i_waddr (spin_waddr),
        .i_wdata (spin_wdata),
        .i_raddr (spin_raddr),
        .o_rdata (spin_rdata)
    );

    xms_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SDEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // assertions
    a_flip_only_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == xms_pkg::ST_FIN && r_flip) |-> (r_kind == xms_pkg::KIND_UPDATE))
        else $error("flip flagged on a non-update word");

    a_mag_only_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != xms_pkg::ST_FIN) |=> $stable(r_mag))
        else $error("magnetization moved outside result stage");

    a_spin_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        spin_we |-> (r_state == xms_pkg::ST_CLEAR || r_state == xms_pkg::ST_FIN))
        else $error("spin RAM written during a read sweep");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == xms_pkg::ST_FIN))
        else $error("result word raised outside result stage");

endmodule

FILE: rtl/xms_ram.sv
// ----------------------------------------------------------------------------
// xms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module xms_ram #(
    parameter int WIDTH = xms_pkg::SLOT_W,
    parameter int DEPTH = xms_pkg::SITES_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
